### hdl/sptg_pkg.sv
// Shared types and constants for the servo pulse and tone generator.
package sptg_pkg;

  localparam int unsigned SERVO_FRAME_TICKS = 40;
  localparam int unsigned FRAME_W = 6;
  localparam int unsigned PW_W = 3;
  localparam int unsigned HALF_W = 10;
  localparam int unsigned TOG_W = 24;
  localparam int unsigned MS_W = 32;
  localparam int unsigned ANGLE_W = 9;
  localparam int unsigned FREQ_W = 16;
  localparam int unsigned DUR_W = 16;
  localparam int unsigned IN_DATA_W = 48;
  localparam int unsigned IN_USER_W = 2;
  localparam int unsigned OUT_DATA_W = 40;

  localparam int unsigned DIV_W = 26;
  localparam int unsigned DVS_W = 19;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_W);

  localparam logic [PW_W-1:0] PW_RESET = PW_W'(3);
  localparam logic [DIV_W-1:0] US_PER_SEC = DIV_W'(1000000);
  localparam logic [DIV_W-1:0] US_PER_MS = DIV_W'(1000);
  localparam logic [DIV_W-1:0] HALF_TICK_US = DIV_W'(250);
  localparam logic [DVS_W-1:0] TICK_US = DVS_W'(500);
  localparam logic signed [ANGLE_W-1:0] ANGLE_PW3 = ANGLE_W'(45);
  localparam logic signed [ANGLE_W-1:0] ANGLE_PW4 = ANGLE_W'(135);

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_SERVO = 2'd1,
    FUNC_TONE  = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_HALF,
    ST_DIV_TICKS,
    ST_DIV_COUNT,
    ST_COMMIT
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

### hdl/servo_pwm_and_tone_generator.sv
// Top level: tick-driven servo pulse, square-wave tone and millisecond counter.
// Tick, servo and stop-tone items: one item per cycle unless the output stalls;
// the result is registered in the cycle after accept. Tone start: three serial
// divisions on the shared bit-serial divider, then a commit step loads the result.
// One output register holds the result; the input stalls while a result waits and during a tone start.
// Reset clears the pin, counter and tone toggle state; pulse width starts at 3 ticks.
module servo_pwm_and_tone_generator (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [8:0] angle_deg, [24:9] tone_freq_hz, [40:25] tone_ms, [47:41] zero
  input  logic [sptg_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // [1:0] func
  input  logic [sptg_pkg::IN_USER_W-1:0]   s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [0] servo_out, [1] buzzer_out, [33:2] ms_count, [34] tone_active, [39:35] zero
  output logic [sptg_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
  import sptg_pkg::*;

  state_e state_q, state_d;

  logic                 parity_q, parity_d;
  logic [MS_W-1:0]      millis_q, millis_d;
  logic [FRAME_W-1:0]   phase_q, phase_d;
  logic [PW_W-1:0]      pw_q, pw_d;
  logic                 servo_q, servo_d;
  logic [HALF_W-1:0]    half_q, half_d;
  logic [TOG_W-1:0]     tog_q, tog_d;
  logic [HALF_W-1:0]    timer_q, timer_d;
  logic                 buz_q, buz_d;
  logic [DVS_W-1:0]     half_us_q, half_us_d;
  logic [DUR_W-1:0]     dur_q, dur_d;

  logic                  out_valid_q, out_valid_d;
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;
  logic                  out_load;
  logic                  out_free;
  logic                  in_acc;

  func_e                      func;
  logic signed [ANGLE_W-1:0]  angle;
  logic [FREQ_W-1:0]          freq;
  logic [DUR_W-1:0]           dur;

  logic                 div_start;
  logic [DIV_W-1:0]     div_dividend;
  logic [DVS_W-1:0]     div_divisor;
  div_stat_t            div_stat;
  logic [DIV_W-1:0]     div_quo;

  logic [FRAME_W-1:0]   phase_inc;
  logic [HALF_W-1:0]    timer_inc;
  logic [TOG_W-1:0]     tog_dec;
  logic [DIV_W-1:0]     dur_us;

  assign func  = func_e'(s_axis_tuser);
  assign angle = signed'(s_axis_tdata[8:0]);
  assign freq  = s_axis_tdata[24:9];
  assign dur   = s_axis_tdata[40:25];

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && out_free;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign phase_inc = phase_q + 1'b1;
  assign timer_inc = timer_q + 1'b1;
  assign tog_dec   = tog_q - 1'b1;
  assign dur_us    = DIV_W'(dur_q) * US_PER_MS;

  sptg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .stat_o     (div_stat),
    .quotient_o (div_quo)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && func == FUNC_TONE && freq != '0 && dur != '0) begin
          state_d = ST_DIV_HALF;
        end
      end
      ST_DIV_HALF: begin
        if (div_stat.done) state_d = ST_DIV_TICKS;
      end
      ST_DIV_TICKS: begin
        if (div_stat.done) state_d = ST_DIV_COUNT;
      end
      ST_DIV_COUNT: begin
        if (div_stat.done) state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    parity_d     = parity_q;
    millis_d     = millis_q;
    phase_d      = phase_q;
    pw_d         = pw_q;
    servo_d      = servo_q;
    half_d       = half_q;
    tog_d        = tog_q;
    timer_d      = timer_q;
    buz_d        = buz_q;
    half_us_d    = half_us_q;
    dur_d        = dur_q;
    out_load     = 1'b0;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (func)
            FUNC_TICK: begin
              out_load = 1'b1;
              parity_d = ~parity_q;
              if (parity_q) millis_d = millis_q + 1'b1;
              phase_d = (phase_inc >= FRAME_W'(SERVO_FRAME_TICKS)) ? '0 : phase_inc;
              if (phase_d == '0) begin
                servo_d = 1'b1;
              end else if (phase_d == FRAME_W'(pw_q)) begin
                servo_d = 1'b0;
              end
              if (half_q != '0) begin
                if (timer_inc >= half_q) begin
                  timer_d = '0;
                  buz_d   = ~buz_q;
                  if (tog_q != '0) begin
                    tog_d = tog_dec;
                    if (tog_dec == '0) begin
                      half_d = '0;
                      buz_d  = 1'b0;
                    end
                  end
                end else begin
                  timer_d = timer_inc;
                end
              end
            end
            FUNC_SERVO: begin
              out_load = 1'b1;
              if (angle < ANGLE_PW3) begin
                pw_d = PW_W'(2);
              end else if (angle < ANGLE_PW4) begin
                pw_d = PW_W'(3);
              end else begin
                pw_d = PW_W'(4);
              end
            end
            FUNC_TONE: begin
              if (freq == '0 || dur == '0) begin
                out_load = 1'b1;
                half_d   = '0;
                tog_d    = '0;
                buz_d    = 1'b0;
              end else begin
                dur_d        = dur;
                div_start    = 1'b1;
                div_dividend = US_PER_SEC;
                div_divisor  = DVS_W'({freq, 1'b0});
              end
            end
            default: out_load = 1'b1;
          endcase
        end
      end
      ST_DIV_HALF: begin
        if (div_stat.done) begin
          half_us_d    = div_quo[DVS_W-1:0];
          div_start    = 1'b1;
          div_dividend = DIV_W'(div_quo[DVS_W-1:0]) + HALF_TICK_US;
          div_divisor  = TICK_US;
        end
      end
      ST_DIV_TICKS: begin
        if (div_stat.done) begin
          half_d       = (div_quo[HALF_W-1:0] == '0) ? HALF_W'(1) : div_quo[HALF_W-1:0];
          div_start    = 1'b1;
          div_dividend = dur_us;
          div_divisor  = half_us_q;
        end
      end
      ST_DIV_COUNT: begin
        if (div_stat.done) tog_d = div_quo[TOG_W-1:0];
      end
      ST_COMMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          timer_d  = '0;
          buz_d    = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_data_d  = {5'b0, half_d != '0, millis_d, buz_d, servo_d};
    out_valid_d = out_load ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      parity_q    <= 1'b0;
      millis_q    <= '0;
      phase_q     <= '0;
      pw_q        <= PW_RESET;
      servo_q     <= 1'b0;
      half_q      <= '0;
      tog_q       <= '0;
      timer_q     <= '0;
      buz_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      parity_q    <= parity_d;
      millis_q    <= millis_d;
      phase_q     <= phase_d;
      pw_q        <= pw_d;
      servo_q     <= servo_d;
      half_q      <= half_d;
      tog_q       <= tog_d;
      timer_q     <= timer_d;
      buz_q       <= buz_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    half_us_q <= half_us_d;
    dur_q     <= dur_d;
    if (out_load) out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  a_done_in_div_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == ST_DIV_HALF || state_q == ST_DIV_TICKS ||
                       state_q == ST_DIV_COUNT))
    else $error("divider finished outside a division step");

  a_start_when_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_stat.busy)
    else $error("divider restarted while busy");

  a_phase_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q < FRAME_W'(SERVO_FRAME_TICKS))
    else $error("frame phase out of range");

  a_timer_below_half : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && half_q != '0) |-> (timer_q < half_q))
    else $error("toggle timer passed half period");

  a_pw_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pw_q == PW_W'(2)) || (pw_q == PW_W'(3)) || (pw_q == PW_W'(4)))
    else $error("pulse width out of range");

  a_load_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> out_free)
    else $error("result loaded over a pending item");

endmodule

### hdl/sptg_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module sptg_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [sptg_pkg::DIV_W-1:0] dividend_i,
  input  logic [sptg_pkg::DVS_W-1:0] divisor_i,
  output sptg_pkg::div_stat_t        stat_o,
  output logic [sptg_pkg::DIV_W-1:0] quotient_o
);
  import sptg_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DVS_W-1:0]     rem_q, rem_d;
  logic [DIV_W-1:0]     quo_q, quo_d;
  logic [DVS_W-1:0]     dvs_q, dvs_d;
  logic [DVS_W:0]       partial;
  logic [DVS_W:0]       diff;
  logic                 fits;

  assign partial = {rem_q, quo_q[DIV_W-1]};
  assign diff    = partial - {1'b0, dvs_q};
  assign fits    = partial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(DIV_W - 1);
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? diff[DVS_W-1:0] : partial[DVS_W-1:0];
      quo_d = {quo_q[DIV_W-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;

endmodule
